>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the radix string converter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error(msg);

// Assertion on the block clock clk and reset arst_n.
`define RSC_ASSERT(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

>>> rtl/rsc_pkg.sv
// ---------------------------------------------------------------------------
// rsc_pkg
// Types, constants and digit mapping helpers of the radix string converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

	localparam int CHAR_W    = 8;
	localparam int BASE_W    = 6;
	localparam int CFG_IDX_W = 4;

	typedef logic [CHAR_W-1:0]    char_t;
	typedef logic [BASE_W-1:0]    base_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t REG_SOURCE_BASE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_TARGET_BASE = cfg_idx_t'(1);

	localparam base_t SOURCE_BASE_RST = 6'd10;
	localparam base_t TARGET_BASE_RST = 6'd16;
	localparam base_t MIN_RADIX       = 6'd2;
	localparam base_t MAX_RADIX       = 6'd36;
	localparam base_t DEC_TEN         = 6'd10;

	localparam char_t CHAR_ZERO    = 8'd48;
	localparam char_t CHAR_NINE    = 8'd57;
	localparam char_t CHAR_A_UPPER = 8'd65;
	localparam char_t CHAR_Z_UPPER = 8'd90;
	localparam char_t CHAR_A_LOWER = 8'd97;

	function automatic base_t clamp_base(input base_t b);
		if (b < MIN_RADIX)
			return MIN_RADIX;
		if (b > MAX_RADIX)
			return MAX_RADIX;
		return b;
	endfunction

	// Two's complement digit value, 9 bits; no validation of the character.
	function automatic logic [8:0] char_to_digit(input char_t c);
		logic [8:0] cx;
		logic [8:0] d_upper;
		cx      = {1'b0, c};
		d_upper = cx - 9'(CHAR_A_UPPER) + 9'(DEC_TEN);
		if (c <= CHAR_NINE)
			return cx - 9'(CHAR_ZERO);
		if (d_upper > 9'(MAX_RADIX))
			return cx - 9'(CHAR_A_LOWER) + 9'(DEC_TEN);
		return d_upper;
	endfunction

	function automatic char_t digit_to_char(input base_t r);
		if (r < DEC_TEN)
			return char_t'(r) + CHAR_ZERO;
		return char_t'(r) - char_t'(DEC_TEN) + CHAR_A_UPPER;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rsc_if.sv
// ---------------------------------------------------------------------------
// rsc_if
// Valid/ready channels of the radix string converter: digit input,
// result output and configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsc_in_if;
	import rsc_pkg::*;
	logic  valid;
	logic  ready;
	char_t digit_char;
	logic  end_of_number;
	modport source (output valid, output digit_char, output end_of_number, input ready);
	modport sink   (input valid, input digit_char, input end_of_number, output ready);
endinterface

interface rsc_out_if;
	import rsc_pkg::*;
	logic  valid;
	logic  ready;
	char_t out_char;
	logic  last_digit;
	modport source (output valid, output out_char, output last_digit, input ready);
	modport sink   (input valid, input out_char, input last_digit, output ready);
endinterface

interface rsc_cfg_if;
	import rsc_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	base_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rsc_ram.sv
// ---------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/rsc_divider.sv
// ---------------------------------------------------------------------------
// rsc_divider
// Bit-serial restoring divider: WIDTH-bit dividend by a 6-bit radix,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_divider #(
	parameter int WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WIDTH-1:0]  dividend,
	input  wire rsc_pkg::base_t    divisor,
	output logic                   done,
	output logic      [WIDTH-1:0]  quotient,
	output rsc_pkg::base_t         remainder
);
	import rsc_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0]  quo_q;
	base_t             rem_q;
	base_t             div_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BASE_W:0]   trial;
	logic              ge;
	logic [BASE_W:0]   nrem;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign nrem  = ge ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits the radix width
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], ge};
			rem_q <= nrem[BASE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/radix_string_converter.sv
// ---------------------------------------------------------------------------
// radix_string_converter
// Folds ASCII digits of a source radix into a value and emits it as ASCII
// digits of a target radix, most significant first.
// ---------------------------------------------------------------------------
// A non-final character is folded into the accumulator by a multiply-add,
// and the next one may follow in the next cycle. On the final character
// the value is divided repeatedly by the target radix in a shared
// bit-serial divider, and the remainders go to a MAX_DIGITS-deep stack
// RAM. They are then read back from the RAM, one per emitted digit. The
// input stays not ready while the number is divided and read back, and is
// ready again while the last digit may still wait on the output.
// Out-of-range radix values act as 2 or 36. If the value needs more than
// MAX_DIGITS digits, only the low MAX_DIGITS digits are emitted.
`default_nettype none

module radix_string_converter #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rsc_in_if.sink    digits,
	rsc_out_if.source result,
	rsc_cfg_if.sink   cfg
);
	import rsc_pkg::*;

	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CNTW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	base_t                  src_base_q;
	base_t                  tgt_base_q;
	base_t                  sb;
	base_t                  tb;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] prod;
	logic [VALUE_WIDTH-1:0] dx;
	logic [VALUE_WIDTH-1:0] fold;
	logic [8:0]             d9;
	logic [CNTW-1:0]        cnt_q;
	logic [CNTW-1:0]        cnt_dec;
	logic                   pend_q;
	logic                   last_pend_q;
	logic                   ovalid_q;
	char_t                  out_char_q;
	logic                   out_last_q;
	logic                   in_fire;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo;
	base_t                  div_rem;
	logic                   stack_we;
	base_t                  stack_rdata;
	logic                   issue;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= SOURCE_BASE_RST;
			tgt_base_q <= TARGET_BASE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SOURCE_BASE: src_base_q <= cfg.data;
				REG_TARGET_BASE: tgt_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign sb = clamp_base(src_base_q);
	assign tb = clamp_base(tgt_base_q);

	// digit folding
	assign d9   = char_to_digit(digits.digit_char);
	assign dx   = VALUE_WIDTH'({{VALUE_WIDTH{d9[8]}}, d9});
	assign prod = acc_q * VALUE_WIDTH'(sb);
	assign fold = prod + dx;

	assign digits.ready = (state_q == S_IDLE);
	assign in_fire      = digits.valid && digits.ready;

	// first division starts straight from the folded value
	assign div_start    = (in_fire && digits.end_of_number) ||
	                      (state_q == S_DIV && div_done && div_quo != '0);
	assign div_dividend = (state_q == S_IDLE) ? fold : div_quo;

	rsc_divider #(
		.WIDTH (VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (tb),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign stack_we = (state_q == S_DIV) && div_done && (cnt_q < CNTW'(MAX_DIGITS));
	assign cnt_dec  = cnt_q - 1'b1;

	rsc_ram #(
		.WIDTH (BASE_W),
		.DEPTH (MAX_DIGITS)
	) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (div_rem),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (stack_rdata)
	);

	// read a stacked digit only when the output register will be free
	assign issue = (state_q == S_EMIT) && !pend_q && (!ovalid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			last_pend_q <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			pend_q <= issue;
			if (issue)
				last_pend_q <= (cnt_q == CNTW'(1));

			if (pend_q)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (digits.end_of_number) begin
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_DIV;
						end else begin
							acc_q <= fold;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (stack_we)
							cnt_q <= cnt_q + 1'b1;
						if (div_quo == '0)
							state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (issue) begin
						cnt_q <= cnt_dec;
						if (cnt_q == CNTW'(1))
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			out_char_q <= digit_to_char(stack_rdata);
			out_last_q <= last_pend_q;
		end
	end

	assign result.valid      = ovalid_q;
	assign result.out_char   = out_char_q;
	assign result.last_digit = out_last_q;

endmodule

`default_nettype wire

>>> rtl/rsc_checker.sv
// ---------------------------------------------------------------------------
// rsc_checker
// Port-level assertions for the radix string converter, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rsc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           in_eon,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire rsc_pkg::char_t out_char,
	input wire logic           out_last
);
	import rsc_pkg::*;

	// a pending result request is held until taken
	`RSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	`RSC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_char) && $stable(out_last),
		"result payload changed while stalled")

	`ASSERT_CLK(a_out_legal, clk, arst_n,
		out_valid |-> ((out_char >= CHAR_ZERO && out_char <= CHAR_NINE) ||
			(out_char >= CHAR_A_UPPER && out_char <= CHAR_Z_UPPER)),
		"emitted character is not a target digit")

	// no new digits taken while a non-final digit of a number is on the output
	`RSC_ASSERT(a_busy_emit, out_valid && !out_last |-> !in_ready, "input ready during emit")

	`RSC_ASSERT(a_busy_conv, in_valid && in_ready && in_eon |=> !in_ready,
		"input ready right after final character")

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (digits.valid),
	.in_ready  (digits.ready),
	.in_eon    (digits.end_of_number),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_char  (result.out_char),
	.out_last  (result.last_digit)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for radix_string_converter. Digit strings go in
// through the digit channel, and converted digits are checked in order
// against a predictor that runs in the scoreboard. Radix registers are
// changed between batches while the block is idle. Both the sender and the
// receiver insert random gaps.
// ---------------------------------------------------------------------------
module tb;
	import rsc_pkg::*;

	localparam int       N_ITEMS       = 260;
	localparam int       IDLE_LIMIT    = 25000;
	localparam int       SETTLE_CYCLES = 20;
	localparam int       MAX_STALL     = 6;
	localparam int       MAX_OUT_DIGITS = 64;
	localparam cfg_idx_t REG_UNUSED    = '1;

	typedef struct {
		char_t ch;
		logic  last;
	} out_digit_t;

	typedef char_t char_q_t[$];

	class radix_scoreboard;
		base_t      src_reg;
		base_t      tgt_reg;
		bit [63:0]  acc;
		out_digit_t digits_due[$];
		int         errors;

		function new();
			src_reg = SOURCE_BASE_RST;
			tgt_reg = TARGET_BASE_RST;
			acc     = '0;
			errors  = 0;
		endfunction

		static function bit [63:0] eff_radix(base_t b);
			if (b < MIN_RADIX)
				return 64'(MIN_RADIX);
			if (b > MAX_RADIX)
				return 64'(MAX_RADIX);
			return 64'(b);
		endfunction

		function void write_reg(cfg_idx_t idx, base_t val);
			if (idx == REG_SOURCE_BASE)
				src_reg = val;
			else if (idx == REG_TARGET_BASE)
				tgt_reg = val;
		endfunction

		// fold one character; on the final one, queue the converted digits
		function void note_char(char_t c, logic eon);
			longint     d;
			bit [63:0]  dbits;
			bit [63:0]  v;
			bit [63:0]  radix;
			bit [5:0]   rems[$];
			out_digit_t od;
			d = longint'(c) - longint'(CHAR_ZERO);
			if (d > 9)
				d = longint'(c) - longint'(CHAR_A_UPPER) + 10;
			if (d > 36)
				d = longint'(c) - longint'(CHAR_A_LOWER) + 10;
			dbits = d;  // negative digits wrap in two's complement
			acc = acc * eff_radix(src_reg) + dbits;
			if (!eon)
				return;
			radix = eff_radix(tgt_reg);
			v = acc;
			do begin
				if (rems.size() < MAX_OUT_DIGITS)
					rems.push_back(6'(v % radix));
				v = v / radix;
			end while (v != 0);
			for (int k = rems.size() - 1; k >= 0; k--) begin
				if (rems[k] < 10)
					od.ch = CHAR_ZERO + char_t'(rems[k]);
				else
					od.ch = char_t'(CHAR_A_UPPER + rems[k] - 10);
				od.last = (k == 0);
				digits_due.push_back(od);
			end
			acc = '0;
		endfunction

		function void check(char_t c, logic last);
			out_digit_t od;
			if (digits_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result out_char=%h last_digit=%b", $time, c, last);
				return;
			end
			od = digits_due.pop_front();
			if (c !== od.ch) begin
				errors++;
				$display("%0t: out_char expected %h actual %h", $time, od.ch, c);
			end
			if (last !== od.last) begin
				errors++;
				$display("%0t: last_digit expected %b actual %b", $time, od.last, last);
			end
		endfunction

		function int pending();
			return digits_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rsc_in_if  digits_if ();
	rsc_out_if result_if ();
	rsc_cfg_if cfg_if ();

	radix_string_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.digits (digits_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	radix_scoreboard sb;
	int              items_sent;
	bit              no_idle;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, MAX_STALL);
	endfunction

	function automatic char_t digit_to_ascii(int dv, bit lower);
		if (dv < 10)
			return char_t'(CHAR_ZERO + dv);
		return char_t'((lower ? CHAR_A_LOWER : CHAR_A_UPPER) + dv - 10);
	endfunction

	// mostly well-formed digits of the source radix, some noise and zero strings
	function automatic char_q_t random_number(int radix);
		char_q_t s;
		int      kind;
		int      r;
		int      len;
		kind = $urandom_range(0, 19);
		r    = $urandom_range(0, 19);
		len  = (r < 16) ? $urandom_range(1, 6) :
			(r < 19) ? $urandom_range(7, 16) : $urandom_range(17, 24);
		for (int i = 0; i < len; i++) begin
			if (kind < 3)
				s.push_back(char_t'($urandom_range(0, 255)));
			else if (kind == 3)
				s.push_back(CHAR_ZERO);
			else
				s.push_back(digit_to_ascii($urandom_range(0, radix - 1),
					bit'($urandom_range(0, 1))));
		end
		return s;
	endfunction

	function automatic base_t pick_base();
		base_t extremes[6] = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
		int    r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return extremes[$urandom_range(0, 5)];
		if (r == 1)
			return base_t'($urandom_range(0, 63));
		return base_t'($urandom_range(2, 36));
	endfunction

	task automatic send_char(char_t c, logic eon);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			digits_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		digits_if.valid         <= 1'b1;
		digits_if.digit_char    <= c;
		digits_if.end_of_number <= eon;
		do @(posedge clk); while (!digits_if.ready);
		sb.note_char(c, eon);
		items_sent++;
	endtask

	task automatic send_number(char_q_t s);
		foreach (s[i])
			send_char(s[i], i == s.size() - 1);
	endtask

	task automatic write_reg(cfg_idx_t idx, base_t val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// stop requests, wait for every digit, then let the block settle
	task automatic drain();
		@(negedge clk);
		digits_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result receiver
	initial begin
		int n;
		forever begin
			n = draw_wait();
			@(negedge clk);
			if (n > 0) begin
				result_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			sb.check(result_if.out_char, result_if.last_digit);
		end
	end

	// watchdog on cycles with no transfer on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((digits_if.valid && digits_if.ready) || (result_if.valid && result_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** radix_string_converter: FAILED **");
		$finish;
	end

	initial begin
		char_q_t s;
		base_t   src;
		base_t   tgt;
		sb                      = new();
		no_idle                 = 1'b0;
		items_sent              = 0;
		arst_n                  = 1'b0;
		digits_if.valid         = 1'b0;
		digits_if.digit_char    = '0;
		digits_if.end_of_number = 1'b0;
		result_if.ready         = 1'b0;
		cfg_if.valid            = 1'b0;
		cfg_if.index            = REG_SOURCE_BASE;
		cfg_if.data             = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset radices: zero, letters, the '[' digit, characters below '0', 0xFF
		send_number({CHAR_ZERO});
		send_number({char_t'("z")});
		send_number({char_t'("[")});
		send_number({8'h00});
		send_number({8'hFF});
		send_number({char_t'(" "), char_t'("7")});
		drain();

		// all-ones value, 64 binary digits
		write_reg(REG_SOURCE_BASE, 6'd16);
		write_reg(REG_TARGET_BASE, 6'd2);
		write_reg(REG_UNUSED, 6'h3F);
		s = {};
		repeat (16) s.push_back(char_t'("f"));
		send_number(s);
		drain();

		items_sent = 0;
		while (items_sent < N_ITEMS) begin
			src = pick_base();
			tgt = pick_base();
			write_reg(REG_SOURCE_BASE, src);
			write_reg(REG_TARGET_BASE, tgt);
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, base_t'($urandom_range(0, 63)));
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6))
				send_number(random_number(int'(radix_scoreboard::eff_radix(src))));
			drain();
		end

		if (sb.errors == 0)
			$display("** radix_string_converter: PASSED **");
		else
			$display("** radix_string_converter: FAILED **");
		$finish;
	end

endmodule
